@@ rtl/core/bbc_pkg.sv @@
// Shared types, constants and codes for the bracket balance checker.
package bbc_pkg;

    // Stack sizing
    localparam int STACK_DEPTH = 16;
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // Decoupling queue sizing (power of two)
    localparam int Q_AW    = 2;
    localparam int Q_DEPTH = 1 << Q_AW;

    // Bracket characters
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;
    localparam logic [7:0] CH_LCURLY  = 8'h7B;
    localparam logic [7:0] CH_RCURLY  = 8'h7D;

    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_MISMATCH = 3'd1,
        ERR_EMPTY    = 3'd2,
        ERR_UNCLOSED = 3'd3,
        ERR_OVERFLOW = 3'd4
    } t_err;

    // Classified byte handed from front end to back end
    typedef struct packed {
        logic  last;
        logic  is_open;
        logic  is_close;
        t_kind kind;
    } t_op;

    // Back-end status, observed at the top level
    typedef struct packed {
        logic [CNT_W-1:0] count;
        t_err             err;
    } t_back_stat;

endpackage

@@ rtl/core/bbc_front.sv @@
// Front end: accepts input bytes and classifies them into stack operations.
module bbc_front
    import bbc_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_character,
    input  logic       i_last_char,
    output logic       o_stall,
    input  logic       i_q_full,
    output logic       o_push,
    output t_op        o_op
);

    // Input handshake follows the queue level
    assign o_push = i_valid && !i_q_full;
    assign o_stall = i_q_full;

    // Byte classification
    always_comb begin
        o_op          = '0;
        o_op.last     = i_last_char;
        o_op.kind     = KIND_PAREN;
        unique case (i_character)
            CH_LPAREN: begin
                o_op.is_open = 1'b1;
                o_op.kind    = KIND_PAREN;
            end
            CH_LSQUARE: begin
                o_op.is_open = 1'b1;
                o_op.kind    = KIND_SQUARE;
            end
            CH_LCURLY: begin
                o_op.is_open = 1'b1;
                o_op.kind    = KIND_CURLY;
            end
            CH_RPAREN: begin
                o_op.is_close = 1'b1;
                o_op.kind     = KIND_PAREN;
            end
            CH_RSQUARE: begin
                o_op.is_close = 1'b1;
                o_op.kind     = KIND_SQUARE;
            end
            CH_RCURLY: begin
                o_op.is_close = 1'b1;
                o_op.kind     = KIND_CURLY;
            end
            default: begin
                o_op.is_open  = 1'b0;
                o_op.is_close = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/bbc_fifo.sv @@
// Short queue of classified operations between front and back end.
module bbc_fifo
    import bbc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_op             i_op,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output t_op             o_op,
    output logic [Q_AW:0]   o_level
);

    t_op            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr;
    logic [Q_AW-1:0] r_rd_ptr;
    logic [Q_AW:0]   r_level;
    logic [Q_AW:0]   n_level;

    assign o_full  = (r_level == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_level != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign o_level = r_level;

    // Occupancy update
    always_comb begin
        n_level = r_level;
        if (i_push && !i_pop) begin
            n_level = r_level + (Q_AW+1)'(1);
        end else if (!i_push && i_pop) begin
            n_level = r_level - (Q_AW+1)'(1);
        end
    end

    // Pointers and level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_level <= n_level;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

endmodule

@@ rtl/core/bbc_back.sv @@
// Back end: bracket stack, error tracking and the result register.
module bbc_back
    import bbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_op         i_op,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_balanced,
    output logic [2:0]  o_error_kind,
    output t_back_stat  o_stat
);

    t_kind            r_stack [STACK_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    t_err             r_err;
    t_err             n_err;
    logic             r_out_valid;
    logic             r_out_balanced;
    t_err             r_out_err;
    t_err             res_err;
    logic [CNT_W-1:0] cnt_m1;
    t_kind            top_kind;
    logic             push_en;
    logic             out_free;

    // A last op needs the result register free; others always proceed
    assign out_free = !r_out_valid || !i_stall;
    assign o_q_pop  = i_q_valid && (!i_op.last || out_free);

    assign cnt_m1   = r_count - CNT_W'(1);
    assign top_kind = r_stack[cnt_m1[IDX_W-1:0]];

    // Stack operation for one popped op
    always_comb begin
        n_count = r_count;
        n_err   = r_err;
        push_en = 1'b0;
        if (o_q_pop && (r_err == ERR_NONE)) begin
            if (i_op.is_open) begin
                if (r_count == CNT_W'(STACK_DEPTH)) begin
                    n_err = ERR_OVERFLOW;
                end else begin
                    push_en = 1'b1;
                    n_count = r_count + CNT_W'(1);
                end
            end else if (i_op.is_close) begin
                if (r_count == '0) begin
                    n_err = ERR_EMPTY;
                end else begin
                    n_count = cnt_m1;
                    if (top_kind != i_op.kind) begin
                        n_err = ERR_MISMATCH;
                    end
                end
            end
        end
        // Result priority: recorded error, then leftover opens
        if (n_err != ERR_NONE) begin
            res_err = n_err;
        end else if (n_count != '0) begin
            res_err = ERR_UNCLOSED;
        end else begin
            res_err = ERR_NONE;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_err       <= ERR_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_q_pop && i_op.last) begin
                r_count     <= '0;
                r_err       <= ERR_NONE;
                r_out_valid <= 1'b1;
            end else begin
                r_count <= n_count;
                r_err   <= n_err;
                if (!i_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop && i_op.last) begin
            r_out_balanced <= (res_err == ERR_NONE);
            r_out_err      <= res_err;
        end
    end

    // Stack storage
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[r_count[IDX_W-1:0]] <= i_op.kind;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_balanced   = r_out_balanced;
    assign o_error_kind = r_out_err;
    assign o_stat.count = r_count;
    assign o_stat.err   = r_err;

endmodule

@@ rtl/core/bracket_balance_checker.sv @@
// Bracket balance checker: checks that ( [ { ) ] } nest correctly per expression.
//
// Input channel: i_valid / o_stall carry one byte (i_character) per transaction,
// with i_last_char set on the final byte of an expression. Output channel:
// o_valid / i_stall carry one result per expression: o_balanced and
// o_error_kind (none, mismatched close, close on empty, unclosed opens,
// stack overflow). Bytes after the first error are ignored until the last one.
// Throughput: one byte per cycle while the queue has room. A front end
// classifies each byte and writes it into a 4-entry queue; the back end pops
// one operation a cycle against a 16-entry stack of 2-bit kinds, except that
// a final operation waits while the result register is held.
// With the queue empty, an accepted last byte is written into the queue, then
// the back end pops it and writes the verdict into the result register.
// When the receiver stalls, the result holds; the back end keeps consuming
// non-final bytes, and only a final byte waits for the result register.
// The input stalls only once the queue fills.
// Reset (synchronous, active low) empties the queue, clears the stack count
// and error, and drops o_valid. Stack contents need no clearing.
module bracket_balance_checker
    import bbc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_character,
    input  logic       i_last_char,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_balanced,
    output logic [2:0] o_error_kind
);

    logic          q_full;
    logic          q_push;
    t_op           f_op;
    logic          q_valid;
    logic          q_pop;
    t_op           q_op;
    logic [Q_AW:0] q_level;
    t_back_stat    b_stat;

    // Front end
    bbc_front u_front (
        .i_valid     (i_valid),
        .i_character (i_character),
        .i_last_char (i_last_char),
        .o_stall     (o_stall),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_op        (f_op)
    );

    // Decoupling queue
    bbc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op),
        .o_level (q_level)
    );

    // Back end
    bbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_op         (q_op),
        .o_q_pop      (q_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_balanced   (o_balanced),
        .o_error_kind (o_error_kind),
        .o_stat       (b_stat)
    );

    // Checks
    a_balanced_matches_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_balanced == (o_error_kind == ERR_NONE)))
        else $error("balanced flag disagrees with error code");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_stat.count <= CNT_W'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_level <= (Q_AW+1)'(Q_DEPTH)) && (q_full == (q_level == (Q_AW+1)'(Q_DEPTH))))
        else $error("queue level inconsistent");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_pop && q_op.last) |=> (b_stat.count == '0 && b_stat.err == ERR_NONE && o_valid))
        else $error("state not cleared after last byte");

endmodule

@@ tb/tb.sv @@
// Testbench for the bracket balance checker: directed table plus random expressions.
`timescale 1ns / 100ps

module tb;
    import bbc_pkg::*;

    localparam int DIRECTED_ROWS  = 26;
    localparam int RANDOM_ITEMS   = 1050;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 10;

    // One input transaction; typed rows carry a hand-written verdict on the last byte
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       typed;
        logic       bal;
        t_err       err;
    } t_stim_row;

    typedef struct {
        bit   bal;
        t_err err;
    } t_verdict;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_HOLD,
        STALL_SPARSE
    } t_stall_mode;

    // Directed rows: extremes of the byte, mismatch with trailing ignored byte,
    // overflow on the 17th open, close on empty after a pop, unclosed open
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{8'h00,      1'b1, 1'b1, 1'b1, ERR_NONE},
        '{8'hFF,      1'b1, 1'b1, 1'b1, ERR_NONE},
        '{CH_LPAREN,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_RCURLY,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LSQUARE, 1'b1, 1'b1, 1'b0, ERR_MISMATCH},
        '{CH_LPAREN,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LSQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LCURLY,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LPAREN,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LSQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LCURLY,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LPAREN,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LSQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LCURLY,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LPAREN,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LSQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LCURLY,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LPAREN,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LSQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LCURLY,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LPAREN,  1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_LCURLY,  1'b1, 1'b1, 1'b0, ERR_OVERFLOW},
        '{CH_LSQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_RSQUARE, 1'b0, 1'b0, 1'b0, ERR_NONE},
        '{CH_RPAREN,  1'b1, 1'b1, 1'b0, ERR_EMPTY},
        '{CH_LCURLY,  1'b1, 1'b1, 1'b0, ERR_UNCLOSED}
    };

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_character  = 8'h00;
    logic       i_last_char  = 1'b0;
    logic       i_stall      = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic       o_balanced;
    logic [2:0] o_error_kind;

    bracket_balance_checker uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_character  (i_character),
        .i_last_char  (i_last_char),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_balanced   (o_balanced),
        .o_error_kind (o_error_kind)
    );

    // Stimulus store and expected verdicts
    t_stim_row   stim_rows[$];
    logic [7:0]  expr_bytes[$];
    t_verdict    expected_verdicts[$];
    int          verdicts_due   = 0;
    int          accepted_bytes = 0;
    int          next_row       = 0;
    int          mismatch_count = 0;
    int          idle_cycles    = 0;

    // Predictor state
    t_kind       nest_stack [STACK_DEPTH];
    int          nest_depth  = 0;
    t_err        first_fault = ERR_NONE;

    // Sender and receiver pacing
    t_stim_row   cur_row;
    int          burst_left  = 1;
    int          gap_left    = 0;
    t_stall_mode stall_mode  = STALL_NONE;
    int          stall_run   = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Predict one accepted byte; a verdict comes out on the last byte only
    task automatic predict_byte(input logic [7:0] ch, input logic last,
                                output bit done, output bit bal, output t_err err);
        bit    is_open;
        bit    is_close;
        t_kind k;
        is_open  = 1'b0;
        is_close = 1'b0;
        k        = KIND_PAREN;
        case (ch)
            CH_LPAREN:  begin is_open  = 1'b1; k = KIND_PAREN;  end
            CH_LSQUARE: begin is_open  = 1'b1; k = KIND_SQUARE; end
            CH_LCURLY:  begin is_open  = 1'b1; k = KIND_CURLY;  end
            CH_RPAREN:  begin is_close = 1'b1; k = KIND_PAREN;  end
            CH_RSQUARE: begin is_close = 1'b1; k = KIND_SQUARE; end
            CH_RCURLY:  begin is_close = 1'b1; k = KIND_CURLY;  end
            default:    ;
        endcase
        // bytes after the first fault are ignored
        if (first_fault == ERR_NONE) begin
            if (is_open) begin
                if (nest_depth >= STACK_DEPTH) begin
                    first_fault = ERR_OVERFLOW;
                end else begin
                    nest_stack[nest_depth] = k;
                    nest_depth++;
                end
            end else if (is_close) begin
                if (nest_depth == 0) begin
                    first_fault = ERR_EMPTY;
                end else begin
                    nest_depth--;
                    if (nest_stack[nest_depth] != k)
                        first_fault = ERR_MISMATCH;
                end
            end
        end
        done = last;
        err  = first_fault;
        bal  = 1'b0;
        if (last) begin
            if (err == ERR_NONE && nest_depth != 0)
                err = ERR_UNCLOSED;
            bal         = (err == ERR_NONE);
            nest_depth  = 0;
            first_fault = ERR_NONE;
        end
    endtask

    function automatic logic [7:0] open_char(input t_kind k);
        case (k)
            KIND_PAREN:  return CH_LPAREN;
            KIND_SQUARE: return CH_LSQUARE;
            default:     return CH_LCURLY;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input t_kind k);
        case (k)
            KIND_PAREN:  return CH_RPAREN;
            KIND_SQUARE: return CH_RSQUARE;
            default:     return CH_RCURLY;
        endcase
    endfunction

    function automatic t_kind rand_kind();
        return t_kind'($urandom_range(0, 2));
    endfunction

    function automatic logic [7:0] rand_bracket();
        if ($urandom_range(0, 1) == 0)
            return open_char(rand_kind());
        return close_char(rand_kind());
    endfunction

    // Any byte that is not a bracket
    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == CH_LPAREN || b == CH_RPAREN || b == CH_LSQUARE ||
               b == CH_RSQUARE || b == CH_LCURLY || b == CH_RCURLY)
            b = 8'($urandom);
        return b;
    endfunction

    // Well-formed nesting with random content, closed out at the end
    task automatic gen_nested(input int max_depth, input int steps);
        t_kind open_kinds[$];
        t_kind k;
        int    r;
        for (int i = 0; i < steps; i++) begin
            r = $urandom_range(0, 9);
            if (r < 4 && open_kinds.size() < max_depth) begin
                k = rand_kind();
                open_kinds.push_back(k);
                expr_bytes.push_back(open_char(k));
            end else if (r < 7 && open_kinds.size() > 0) begin
                expr_bytes.push_back(close_char(open_kinds.pop_back()));
            end else begin
                expr_bytes.push_back(filler_byte());
            end
        end
        while (open_kinds.size() > 0) begin
            if ($urandom_range(0, 4) == 0)
                expr_bytes.push_back(filler_byte());
            expr_bytes.push_back(close_char(open_kinds.pop_back()));
        end
    endtask

    // Move the built expression into the stimulus store, marking its last byte
    task automatic emit_expr();
        t_stim_row row;
        for (int i = 0; i < expr_bytes.size(); i++) begin
            row       = '0;
            row.ch    = expr_bytes[i];
            row.last  = (i == expr_bytes.size() - 1);
            row.typed = 1'b0;
            row.err   = ERR_NONE;
            stim_rows.push_back(row);
        end
        expr_bytes.delete();
    endtask

    task automatic build_random();
        int sel;
        int depth_cap;
        int pos;
        t_kind k;
        while (stim_rows.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
            sel       = $urandom_range(0, 99);
            depth_cap = ($urandom_range(0, 7) == 0) ? STACK_DEPTH : $urandom_range(1, 6);
            if (sel < 50) begin
                gen_nested(depth_cap, $urandom_range(1, 24));
            end else if (sel < 70) begin
                // well-formed text with one byte changed, dropped or inserted
                gen_nested(depth_cap, $urandom_range(1, 24));
                pos = $urandom_range(0, expr_bytes.size() - 1);
                case ($urandom_range(0, 2))
                    0: expr_bytes[pos] = rand_bracket();
                    1: if (expr_bytes.size() > 1) expr_bytes.delete(pos);
                    default: expr_bytes.insert(pos, rand_bracket());
                endcase
            end else if (sel < 78) begin
                // more opens than the stack holds, then up to four random brackets
                repeat ($urandom_range(STACK_DEPTH + 1, STACK_DEPTH + 4))
                    expr_bytes.push_back(open_char(rand_kind()));
                repeat ($urandom_range(0, 4))
                    expr_bytes.push_back(rand_bracket());
            end else if (sel < 85) begin
                // exactly full stack, closed in order
                t_kind full_kinds[$];
                for (int i = 0; i < STACK_DEPTH; i++) begin
                    k = rand_kind();
                    full_kinds.push_back(k);
                    expr_bytes.push_back(open_char(k));
                end
                while (full_kinds.size() > 0)
                    expr_bytes.push_back(close_char(full_kinds.pop_back()));
            end else begin
                // noise with many brackets
                repeat ($urandom_range(1, 12)) begin
                    if ($urandom_range(0, 1) == 0)
                        expr_bytes.push_back(rand_bracket());
                    else
                        expr_bytes.push_back(8'($urandom));
                end
            end
            emit_expr();
        end
    endtask

    // Single clocked process: check both channels, then drive the next cycle
    always @(posedge i_clk) begin
        bit       in_take;
        bit       out_take;
        bit       got;
        bit       pbal;
        t_err     perr;
        bit       stall_bit;
        t_verdict v;
        if (i_rst_n) begin
            in_take  = i_valid && !o_stall;
            out_take = o_valid && !i_stall;

            // result side
            if (out_take) begin
                if (expected_verdicts.size() == 0) begin
                    report_mismatch("result with no expected verdict waiting");
                end else begin
                    v = expected_verdicts.pop_front();
                    verdicts_due--;
                    if (o_balanced !== v.bal)
                        report_mismatch($sformatf("balanced %b, expected %b",
                                                  o_balanced, v.bal));
                    if (o_error_kind !== v.err)
                        report_mismatch($sformatf("error_kind %0d, expected %0d",
                                                  o_error_kind, v.err));
                end
            end

            // byte side
            if (in_take) begin
                predict_byte(i_character, i_last_char, got, pbal, perr);
                if (got) begin
                    if (cur_row.typed) begin
                        v.bal = cur_row.bal;
                        v.err = cur_row.err;
                    end else begin
                        v.bal = pbal;
                        v.err = perr;
                    end
                    expected_verdicts.push_back(v);
                    verdicts_due++;
                end
                accepted_bytes++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        9:       gap_left = $urandom_range(10, 24);
                        default: gap_left = $urandom_range(1, 6);
                    endcase
                end
            end

            idle_cycles = (in_take || out_take) ? 0 : idle_cycles + 1;

            // sender: bursts and gaps, payload held while stalled
            if (!i_valid || in_take) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid     <= 1'b0;
                    i_character <= 8'($urandom);
                    i_last_char <= 1'($urandom);
                end else if (next_row < stim_rows.size()) begin
                    cur_row = stim_rows[next_row];
                    next_row++;
                    i_valid     <= 1'b1;
                    i_character <= cur_row.ch;
                    i_last_char <= cur_row.last;
                end else begin
                    i_valid <= 1'b0;
                end
            end

            // receiver: stall pattern in runs of random mode
            if (stall_run == 0) begin
                stall_mode = t_stall_mode'($urandom_range(0, 3));
                stall_run  = $urandom_range(1, 40);
            end
            stall_run--;
            case (stall_mode)
                STALL_NONE:   stall_bit = 1'b0;
                STALL_COIN:   stall_bit = 1'($urandom_range(0, 1));
                STALL_HOLD:   stall_bit = 1'b1;
                default:      stall_bit = ($urandom_range(0, 7) == 0);
            endcase
            i_stall <= stall_bit;
        end
    end

    // Watchdog on cycles without any transaction
    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("tb failed");
        $finish;
    end

    // Build stimulus, release reset, wait for the drain, then the verdict
    initial begin
        for (int i = 0; i < DIRECTED_ROWS; i++)
            stim_rows.push_back(DIRECTED[i]);
        build_random();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (accepted_bytes == stim_rows.size());
        wait (verdicts_due == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
